/* hdl/fis_pkg.sv */
// ----------------------------------------------------------------------------
// fis_pkg
// Shared constants for the frame interval statistics unit: field widths,
// configuration register indexes and reset values.
// ----------------------------------------------------------------------------
package fis_pkg;

  localparam int DEFAULT_WINDOW_DEPTH = 64;
  localparam int DEFAULT_STAMP_WIDTH  = 48;

  localparam int TPS_W      = 40;
  localparam int MIN_W      = 32;
  localparam int FRAME_W    = 32;
  localparam int RATE_W     = 16;
  localparam int ACCUM_W    = 48;
  localparam int CFG_DATA_W = 40;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_SECOND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_FRAME_TICKS  = 2'd1;

  localparam logic [TPS_W-1:0]   TPS_RESET = 40'd1000;
  localparam logic [ACCUM_W-1:0] ACCUM_MAX = 48'hFFFF_FFFF_FFFF;
  localparam logic [RATE_W-1:0]  RATE_MAX  = 16'hFFFF;

endpackage

/* hdl/fis_ram.sv */
// ----------------------------------------------------------------------------
// fis_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module fis_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* hdl/fis_div.sv */
// ----------------------------------------------------------------------------
// fis_div
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fis_div #(
  parameter int NUM_W = 38,
  parameter int DEN_W = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] dividend_i,
  input  logic [DEN_W-1:0] divisor_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quotient_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0] quo_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W:0]   trial;
  logic             ge;
  logic [DEN_W:0]   diff;

  assign trial = {rem_q, quo_q[NUM_W-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[NUM_W-2:0], ge};
      rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

/* hdl/frame_interval_statistics_unit.sv */
// ----------------------------------------------------------------------------
// frame_interval_statistics_unit
// Measures frame intervals from counter timestamps and reports the frame
// length, the windowed mean interval and the frame rate of the last second.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake             Payload
//   in       input      in_valid_i/in_stall_o now_ticks_i
//   out      output     out_valid_o/out_stall_i frame_ticks_o, avg_frame_ticks_o,
//                                             frame_rate_o
//   cfg      input      cfg_we_i              cfg_index_i, cfg_data_i
//
// The first timestamp after reset is only stored, a poll returns to idle after
// the difference and check states, and a frame end is dominated by the
// bit-serial division of the window sum by the sample count.
// The interval window lives in a RAM with a registered read port.
// Reset clears all control state; the RAM needs no clearing.
// A new transaction is taken while a finished result waits on a stalled output.
// ----------------------------------------------------------------------------
module frame_interval_statistics_unit #(
  parameter int WINDOW_DEPTH = fis_pkg::DEFAULT_WINDOW_DEPTH,
  parameter int STAMP_WIDTH  = fis_pkg::DEFAULT_STAMP_WIDTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [STAMP_WIDTH-1:0]          now_ticks_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [fis_pkg::FRAME_W-1:0]     frame_ticks_o,
  output logic [fis_pkg::FRAME_W-1:0]     avg_frame_ticks_o,
  output logic [fis_pkg::RATE_W-1:0]      frame_rate_o,
  input  logic                            cfg_we_i,
  input  logic [fis_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [fis_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int IDX_W     = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_W     = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W     = fis_pkg::FRAME_W + CNT_W;
  localparam int ACC_SUM_W =
    ((STAMP_WIDTH > fis_pkg::ACCUM_W) ? STAMP_WIDTH : fis_pkg::ACCUM_W) + 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIFF  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_FRAME = 3'd3;
  localparam logic [2:0] S_PUSH  = 3'd4;
  localparam logic [2:0] S_RATE  = 3'd5;
  localparam logic [2:0] S_DIV   = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0]                    state_q, state_d;
  logic [fis_pkg::TPS_W-1:0]     tps_q;
  logic [fis_pkg::MIN_W-1:0]     min_q;
  logic [STAMP_WIDTH-1:0]        last_stamp_q;
  logic                          have_stamp_q;
  logic [STAMP_WIDTH-1:0]        now_q;
  logic [STAMP_WIDTH-1:0]        elapsed_q;
  logic [fis_pkg::FRAME_W-1:0]   frame_q;
  logic [fis_pkg::FRAME_W-1:0]   diff_q;
  logic [IDX_W-1:0]              head_q;
  logic [CNT_W-1:0]              total_q;
  logic [SUM_W-1:0]              sum_q;
  logic [fis_pkg::FRAME_W-1:0]   mean_q;
  logic [fis_pkg::RATE_W-1:0]    frames_q;
  logic [fis_pkg::ACCUM_W-1:0]   accum_q;
  logic [fis_pkg::RATE_W-1:0]    rate_q;
  logic                          out_valid_q;
  logic [fis_pkg::FRAME_W-1:0]   out_frame_q;
  logic [fis_pkg::FRAME_W-1:0]   out_mean_q;
  logic [fis_pkg::RATE_W-1:0]    out_rate_q;

  logic                          in_accept;
  logic                          out_free;
  logic [63:0]                   elapsed_ext;
  logic                          is_poll;
  logic [fis_pkg::FRAME_W-1:0]   frame_sat;
  logic                          push;
  logic                          full;
  logic [fis_pkg::FRAME_W-1:0]   ring_rdata;
  logic [SUM_W-1:0]              sum_next;
  logic [ACC_SUM_W-1:0]          acc_sum;
  logic                          div_start;
  logic                          div_done;
  logic [SUM_W-1:0]              div_quotient;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;

  assign elapsed_ext = 64'(elapsed_q);
  assign is_poll     = (min_q != '0) && (elapsed_ext < 64'(min_q));
  assign frame_sat   = (|elapsed_ext[63:32]) ? '1 : elapsed_ext[31:0];

  assign push        = fis_pkg::TPS_W'(diff_q) < tps_q;
  assign full        = total_q == CNT_W'(WINDOW_DEPTH);
  assign sum_next    = sum_q + SUM_W'(frame_q) - (full ? SUM_W'(ring_rdata) : '0);
  assign acc_sum     = ACC_SUM_W'(accum_q) + ACC_SUM_W'(elapsed_q);
  assign div_start   = (state_q == S_RATE) && (total_q != '0);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_accept && have_stamp_q) begin
          state_d = S_DIFF;
        end
      end
      S_DIFF:  state_d = S_CHECK;
      S_CHECK: state_d = is_poll ? S_IDLE : S_FRAME;
      S_FRAME: state_d = S_PUSH;
      S_PUSH:  state_d = S_RATE;
      S_RATE:  state_d = (total_q != '0) ? S_DIV : S_OUT;
      S_DIV: begin
        if (div_done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      tps_q        <= fis_pkg::TPS_RESET;
      min_q        <= '0;
      last_stamp_q <= '0;
      have_stamp_q <= 1'b0;
      head_q       <= '0;
      total_q      <= '0;
      sum_q        <= '0;
      mean_q       <= '0;
      frames_q     <= '0;
      accum_q      <= '0;
      rate_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          fis_pkg::CFG_TICKS_PER_SECOND: tps_q <= cfg_data_i[fis_pkg::TPS_W-1:0];
          fis_pkg::CFG_MIN_FRAME_TICKS:  min_q <= cfg_data_i[fis_pkg::MIN_W-1:0];
          default: ;
        endcase
      end
      if ((state_q == S_IDLE) && in_accept && !have_stamp_q) begin
        last_stamp_q <= now_ticks_i;
        have_stamp_q <= 1'b1;
      end
      if ((state_q == S_CHECK) && !is_poll) begin
        last_stamp_q <= now_q;
      end
      if (state_q == S_PUSH) begin
        if (push) begin
          sum_q  <= sum_next;
          head_q <= (head_q == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : head_q + 1'b1;
          if (!full) begin
            total_q <= total_q + 1'b1;
          end
        end
        if (frames_q != fis_pkg::RATE_MAX) begin
          frames_q <= frames_q + 1'b1;
        end
        accum_q <= (acc_sum > ACC_SUM_W'(fis_pkg::ACCUM_MAX)) ? fis_pkg::ACCUM_MAX
                                                          : acc_sum[fis_pkg::ACCUM_W-1:0];
      end
      if (state_q == S_RATE) begin
        if (accum_q > fis_pkg::ACCUM_W'(tps_q)) begin
          rate_q   <= frames_q;
          frames_q <= '0;
          accum_q  <= '0;
        end
        if (total_q == '0) begin
          mean_q <= '0;
        end
      end
      if ((state_q == S_DIV) && div_done) begin
        mean_q <= div_quotient[fis_pkg::FRAME_W-1:0];
      end
      if ((state_q == S_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      now_q <= now_ticks_i;
    end
    if (state_q == S_DIFF) begin
      elapsed_q <= now_q - last_stamp_q;
    end
    if (state_q == S_CHECK) begin
      frame_q <= frame_sat;
    end
    if (state_q == S_FRAME) begin
      diff_q <= (frame_q >= mean_q) ? frame_q - mean_q : mean_q - frame_q;
    end
    if ((state_q == S_OUT) && out_free) begin
      out_frame_q <= frame_q;
      out_mean_q  <= mean_q;
      out_rate_q  <= rate_q;
    end
  end

  fis_ram #(
    .WIDTH (fis_pkg::FRAME_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    ((state_q == S_PUSH) && push),
    .waddr_i (head_q),
    .wdata_i (frame_q),
    .re_i    (state_q == S_FRAME),
    .raddr_i (head_q),
    .rdata_o (ring_rdata)
  );

  fis_div #(
    .NUM_W (SUM_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q),
    .divisor_i  (total_q),
    .done_o     (div_done),
    .quotient_o (div_quotient)
  );

  assign out_valid_o       = out_valid_q;
  assign frame_ticks_o     = out_frame_q;
  assign avg_frame_ticks_o = out_mean_q;
  assign frame_rate_o      = out_rate_q;

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= CNT_W'(WINDOW_DEPTH))
    else $error("Sample count exceeds the window depth.");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> (total_q != '0))
    else $error("Divider started with a zero sample count.");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_OUT))
    else $error("Result appeared without a completed frame.");

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("Division finished outside the division phase.");

endmodule

/* verif/tb_frame_interval_statistics_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_frame_interval_statistics_unit
// Self-checking testbench for the frame interval statistics unit. It feeds
// counter timestamps and keeps its own model of the frame statistics: first
// stamp, polls below the minimum frame length, outlier rejection, the
// 64-entry interval window, the per-second rate latch, and saturation of the
// frame length and the accumulated time. Every result transaction is
// compared field by field with the oldest prediction. Directed cases come
// first, then a long output hold-off, then randomized phases under several
// register settings and several patterns of sender idling and receiver stall.
// ----------------------------------------------------------------------------
module tb_frame_interval_statistics_unit;

  localparam int CLK_HALF        = 5;
  localparam int RESET_CYCLES    = 11;
  localparam int SETTLE_CYCLES   = 80;
  localparam int HOLD_OFF_CYCLES = 600;
  localparam int PHASE_ITEMS     = 165;
  localparam int PHASES          = 8;
  localparam int DEPTH           = fis_pkg::DEFAULT_WINDOW_DEPTH;
  localparam int HIST_IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int STAMP_W         = fis_pkg::DEFAULT_STAMP_WIDTH;
  localparam longint TIMEOUT_NS  = 64'd20_000_000;

  localparam logic [fis_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED_A = 2'd2;
  localparam logic [fis_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED_B = 2'd3;

  typedef struct packed {
    logic [fis_pkg::FRAME_W-1:0] frame;
    logic [fis_pkg::FRAME_W-1:0] avg;
    logic [fis_pkg::RATE_W-1:0]  rate;
  } frame_stats_t;

  logic                           clk_i       = 1'b0;
  logic                           rst_ni      = 1'b0;
  logic                           in_valid_i  = 1'b0;
  logic                           in_stall_o;
  logic [STAMP_W-1:0]             now_ticks_i = '0;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  logic [fis_pkg::FRAME_W-1:0]    frame_ticks_o;
  logic [fis_pkg::FRAME_W-1:0]    avg_frame_ticks_o;
  logic [fis_pkg::RATE_W-1:0]     frame_rate_o;
  logic                           cfg_we_i    = 1'b0;
  logic [fis_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [fis_pkg::CFG_DATA_W-1:0] cfg_data_i  = '0;

  // Model state, mirroring the block after reset.
  logic [fis_pkg::TPS_W-1:0]   cfg_tps       = fis_pkg::TPS_RESET;
  logic [fis_pkg::MIN_W-1:0]   cfg_min_frame = '0;
  logic [STAMP_W-1:0]          prev_stamp    = '0;
  logic                        stamp_seen    = 1'b0;
  logic [fis_pkg::FRAME_W-1:0] interval_hist [DEPTH];
  logic [HIST_IDX_W-1:0]       hist_wr_ptr   = '0;
  int                          hist_count    = 0;
  logic [63:0]                 hist_sum      = '0;
  logic [fis_pkg::FRAME_W-1:0] avg_interval  = '0;
  logic [fis_pkg::RATE_W-1:0]  frame_count   = '0;
  logic [fis_pkg::ACCUM_W-1:0] accum_ticks   = '0;
  logic [fis_pkg::RATE_W-1:0]  rate_latched  = '0;

  frame_stats_t       pending_stats [$];
  logic [STAMP_W-1:0] sent_stamp     = '0;
  int unsigned        idle_pct       = 0;
  int unsigned        stall_pct      = 0;
  logic               hold_off_req   = 1'b0;
  int unsigned        hold_off_left  = 0;
  int                 mismatch_count = 0;

  frame_interval_statistics_unit u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .now_ticks_i       (now_ticks_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .frame_ticks_o     (frame_ticks_o),
    .avg_frame_ticks_o (avg_frame_ticks_o),
    .frame_rate_o      (frame_rate_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $time, what);
    mismatch_count++;
  endtask

  // Updates the model for one accepted timestamp and queues the expected
  // result when the timestamp ends a frame.
  function automatic void advance_frame_stats(input logic [STAMP_W-1:0] stamp);
    logic [STAMP_W-1:0]          elapsed;
    logic [fis_pkg::FRAME_W-1:0] frame;
    logic [fis_pkg::FRAME_W-1:0] diff;
    frame_stats_t                res;
    if (!stamp_seen) begin
      prev_stamp = stamp;
      stamp_seen = 1'b1;
      return;
    end
    elapsed = stamp - prev_stamp;
    if (cfg_min_frame != 0 && elapsed < STAMP_W'(cfg_min_frame)) return;
    prev_stamp = stamp;
    frame = (elapsed[STAMP_W-1:fis_pkg::FRAME_W] != 0) ? '1
                                                        : elapsed[fis_pkg::FRAME_W-1:0];
    diff = (frame >= avg_interval) ? frame - avg_interval : avg_interval - frame;
    if (fis_pkg::TPS_W'(diff) < cfg_tps) begin
      if (hist_count >= DEPTH) hist_sum -= 64'(interval_hist[hist_wr_ptr]);
      interval_hist[hist_wr_ptr] = frame;
      hist_sum += 64'(frame);
      hist_wr_ptr = (hist_wr_ptr == HIST_IDX_W'(DEPTH - 1)) ? '0 : hist_wr_ptr + 1'b1;
      if (hist_count < DEPTH) hist_count++;
    end
    if (frame_count != fis_pkg::RATE_MAX) frame_count++;
    if (elapsed > fis_pkg::ACCUM_MAX - accum_ticks) begin
      accum_ticks = fis_pkg::ACCUM_MAX;
    end else begin
      accum_ticks += elapsed;
    end
    if (fis_pkg::ACCUM_W'(accum_ticks) > fis_pkg::ACCUM_W'(cfg_tps)) begin
      rate_latched = frame_count;
      frame_count  = '0;
      accum_ticks  = '0;
    end
    avg_interval = (hist_count == 0) ? '0
                                     : fis_pkg::FRAME_W'(hist_sum / 64'(hist_count));
    res.frame = frame;
    res.avg   = avg_interval;
    res.rate  = rate_latched;
    pending_stats.push_back(res);
  endfunction

  task automatic send_stamp(input logic [STAMP_W-1:0] stamp);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    now_ticks_i <= stamp;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    advance_frame_stats(stamp);
    sent_stamp = stamp;
  endtask

  task automatic send_delta(input logic [STAMP_W-1:0] delta);
    send_stamp(sent_stamp + delta);
  endtask

  task automatic wait_until_idle();
    in_valid_i <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [fis_pkg::CFG_IDX_W-1:0] idx,
                           input logic [fis_pkg::CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    unique case (idx)
      fis_pkg::CFG_TICKS_PER_SECOND: cfg_tps = data[fis_pkg::TPS_W-1:0];
      fis_pkg::CFG_MIN_FRAME_TICKS:  cfg_min_frame = data[fis_pkg::MIN_W-1:0];
      default: ;
    endcase
  endtask

  always @(posedge clk_i) begin
    if (hold_off_req) begin
      hold_off_left = HOLD_OFF_CYCLES;
      hold_off_req  = 1'b0;
    end
    if (hold_off_left != 0) begin
      hold_off_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin : check_results
    frame_stats_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_stats.size() == 0) begin
        report_mismatch("result transaction with no pending expectation");
      end else begin
        want = pending_stats.pop_front();
        if (frame_ticks_o !== want.frame)
          report_mismatch($sformatf("frame_ticks %0d, expected %0d",
                                    frame_ticks_o, want.frame));
        if (avg_frame_ticks_o !== want.avg)
          report_mismatch($sformatf("avg_frame_ticks %0d, expected %0d",
                                    avg_frame_ticks_o, want.avg));
        if (frame_rate_o !== want.rate)
          report_mismatch($sformatf("frame_rate %0d, expected %0d",
                                    frame_rate_o, want.rate));
      end
    end
  end

  // Default registers: first stamp, an accepted interval, then an outlier
  // that also closes the one-second window.
  task automatic test_reset_defaults();
    send_stamp('0);
    send_delta(16);
    send_delta(5000);
  endtask

  // All-ones and all-zero stamps: counter wrap, saturated frame length and
  // saturation of the accumulated time.
  task automatic test_counter_extremes();
    wait_until_idle();
    write_cfg(fis_pkg::CFG_TICKS_PER_SECOND, '1);
    send_stamp('1);
    send_stamp('0);
    send_stamp('1);
    send_stamp('0);
  endtask

  task automatic test_frame_limit();
    wait_until_idle();
    write_cfg(fis_pkg::CFG_TICKS_PER_SECOND, 40'd1000000);
    write_cfg(fis_pkg::CFG_MIN_FRAME_TICKS, 40'd1000);
    send_delta(400);
    send_delta(300);
    send_delta(300);
    send_delta(999);
    send_delta(1);
    wait_until_idle();
    write_cfg(fis_pkg::CFG_MIN_FRAME_TICKS, 40'hFF_FFFF_FFFF);
    send_delta(48'hFFFF_FFFE);
    send_delta(1);
    wait_until_idle();
    write_cfg(fis_pkg::CFG_MIN_FRAME_TICKS, '0);
  endtask

  task automatic test_zero_tps();
    wait_until_idle();
    write_cfg(fis_pkg::CFG_TICKS_PER_SECOND, '0);
    send_delta(10);
    send_delta(0);
    send_delta(20);
  endtask

  task automatic test_unmapped_index();
    wait_until_idle();
    write_cfg(CFG_UNMAPPED_A, '1);
    write_cfg(CFG_UNMAPPED_B, '0);
    send_delta(10);
  endtask

  // The receiver holds off long enough for the block to fill and stall its
  // input while the sender keeps offering transactions.
  task automatic test_output_backpressure();
    wait_until_idle();
    write_cfg(fis_pkg::CFG_TICKS_PER_SECOND, 40'd100000);
    write_cfg(fis_pkg::CFG_MIN_FRAME_TICKS, '0);
    idle_pct  = 0;
    stall_pct = 0;
    hold_off_req = 1'b1;
    for (int i = 0; i < 40; i++) send_delta(STAMP_W'(100 + $urandom_range(20)));
    wait_until_idle();
  endtask

  task automatic test_random_traffic();
    logic [fis_pkg::TPS_W-1:0] tps;
    logic [fis_pkg::MIN_W-1:0] min_len;
    logic [STAMP_W-1:0]        base;
    logic [STAMP_W-1:0]        delta;
    int unsigned               kind;
    for (int ph = 0; ph < PHASES; ph++) begin
      unique case (ph)
        0: begin
          tps = 40'd1000; min_len = '0; base = 50;
        end
        1: begin
          tps = fis_pkg::TPS_W'($urandom_range(200000, 2000)); min_len = '0;
          base = STAMP_W'(tps / fis_pkg::TPS_W'($urandom_range(60, 4)));
        end
        2: begin
          tps = 40'd1; min_len = '0; base = 7;
        end
        3: begin
          tps = '1; min_len = '0; base = 48'h0100_0000;
        end
        4: begin
          tps = 40'd500000; min_len = 32'd20000; base = 25000;
        end
        5: begin
          tps = 40'd3000; min_len = '1; base = 48'hFFFF_FFFF;
        end
        6: begin
          tps = fis_pkg::TPS_W'($urandom_range(100000, 100));
          min_len = fis_pkg::MIN_W'($urandom_range(500, 1));
          base = STAMP_W'(min_len) + STAMP_W'($urandom_range(500));
        end
        default: begin
          tps = fis_pkg::TPS_W'({$urandom, $urandom});
          min_len = fis_pkg::MIN_W'($urandom);
          base = STAMP_W'(min_len) + STAMP_W'($urandom_range(1000));
        end
      endcase
      wait_until_idle();
      write_cfg(fis_pkg::CFG_TICKS_PER_SECOND, fis_pkg::CFG_DATA_W'(tps));
      write_cfg(fis_pkg::CFG_MIN_FRAME_TICKS, fis_pkg::CFG_DATA_W'(min_len));
      unique case (ph % 4)
        0: begin
          idle_pct = 0;  stall_pct = 0;
        end
        1: begin
          idle_pct = 59; stall_pct = 0;
        end
        2: begin
          idle_pct = 0;  stall_pct = 59;
        end
        default: begin
          idle_pct = 32; stall_pct = 32;
        end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        kind = $urandom_range(99);
        if (kind < 70) begin
          delta = base + STAMP_W'($urandom_range(32'(base >> 3)));
        end else if (kind < 80) begin
          if (min_len != 0) begin
            delta = STAMP_W'($urandom_range(min_len - 1));
          end else begin
            delta = STAMP_W'($urandom_range(3));
          end
        end else if (kind < 90) begin
          delta = base + STAMP_W'(tps) + STAMP_W'($urandom_range(1000));
        end else if (kind < 95) begin
          delta = STAMP_W'({$urandom, $urandom});
        end else begin
          delta = STAMP_W'($urandom_range(1));
        end
        send_delta(delta);
      end
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_counter_extremes();
    test_frame_limit();
    test_zero_tps();
    test_unmapped_index();
    test_output_backpressure();
    test_random_traffic();
    wait_until_idle();
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("[%0t] Timeout waiting for the block", $time);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
